// File: rtl/rsmp_pkg.sv
// Package for the fixed-spacing path resampler: widths, limits, datapath
// op codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package rsmp_pkg;

	localparam int MAX_POINTS = 64;
	localparam int FRAC_BITS  = 16;
	localparam int PTW        = $clog2(MAX_POINTS);   // point index width
	localparam int CW         = 32;                   // coordinate word
	localparam int SPW        = 23;                   // spacing register
	localparam int DW         = 33;                   // segment length, floor(sqrt) of 65 bits
	localparam int SQW        = 2 * DW;               // radicand, padded to even width
	localparam int SRW        = DW + 3;               // sqrt partial remainder
	localparam int NUMW       = 2 * CW;               // divider numerator
	localparam int NAX        = 3;                    // x, y, yaw
	localparam int SQRT_ITERS = DW;
	localparam int CNTW       = $clog2(SQRT_ITERS + 1);

	// 0.05 m, rounded
	localparam logic [SPW-1:0] SPACING_RESET =
		SPW'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [PTW-1:0] LAST_IDX = PTW'(MAX_POINTS - 1);

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_SQX      = 4'd2;
	localparam logic [3:0] OP_SQY      = 4'd3;
	localparam logic [3:0] OP_SQRT     = 4'd4;
	localparam logic [3:0] OP_CMP      = 4'd5;
	localparam logic [3:0] OP_MUL_OW   = 4'd6;
	localparam logic [3:0] OP_MUL_ST   = 4'd7;
	localparam logic [3:0] OP_DIV_PROD = 4'd8;
	localparam logic [3:0] OP_WR_Q     = 4'd9;
	localparam logic [3:0] OP_WR_QA    = 4'd10;
	localparam logic [3:0] OP_DIV_CNT  = 4'd11;
	localparam logic [3:0] OP_CNT_WR   = 4'd12;
	localparam logic [3:0] OP_EMIT     = 4'd13;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] axis;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic           short_seg;
		logic           div_busy;
		logic           out_free;
		logic [PTW-1:0] n_m1;
	} stat_t;

endpackage

// File: rtl/rsmp_seg_if.sv
// Input channel: one path segment per item.
// Depends on nothing.
`timescale 1ns / 1ps
interface rsmp_seg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] prev_x;
	logic signed [31:0] prev_y;
	logic signed [31:0] prev_yaw;
	logic signed [31:0] cur_x;
	logic signed [31:0] cur_y;
	logic signed [31:0] cur_yaw;

	modport source(output valid, prev_x, prev_y, prev_yaw, cur_x, cur_y, cur_yaw,
		input ready);
	modport sink(input valid, prev_x, prev_y, prev_yaw, cur_x, cur_y, cur_yaw,
		output ready);
endinterface

// File: rtl/rsmp_pnt_if.sv
// Output channel: one resampled point per item.
// Depends on nothing.
`timescale 1ns / 1ps
interface rsmp_pnt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_yaw;
	logic               last_point;
	logic               truncated;

	modport source(output valid, out_x, out_y, out_yaw, last_point, truncated,
		input ready);
	modport sink(input valid, out_x, out_y, out_yaw, last_point, truncated,
		output ready);
endinterface

// File: rtl/rsmp_cfg_if.sv
// Configuration write channel for the spacing register.
// Depends on nothing.
`timescale 1ns / 1ps
interface rsmp_cfg_if;
	logic        valid;
	logic        ready;
	logic [22:0] spacing;

	modport source(output valid, spacing, input ready);
	modport sink(input valid, spacing, output ready);
endinterface

// File: rtl/rsmp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rsmp_pkg.
`timescale 1ns / 1ps
module rsmp_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rsmp_pkg::NUMW-1:0] num,
	input  logic [rsmp_pkg::DW-1:0]   den,
	output logic [rsmp_pkg::NUMW-1:0] quo,
	output logic [rsmp_pkg::DW-1:0]   rem,
	output logic                     busy
);
	localparam int ITW = $clog2(rsmp_pkg::NUMW + 1);

	logic [ITW-1:0]            iter_q;
	logic [rsmp_pkg::NUMW-1:0] num_q;
	logic [rsmp_pkg::DW-1:0]   rem_q;
	logic [rsmp_pkg::DW-1:0]   den_q;
	logic [rsmp_pkg::DW:0]     trial;
	logic                      ge;

	assign trial = {rem_q, num_q[rsmp_pkg::NUMW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (start) begin
			iter_q <= ITW'(rsmp_pkg::NUMW);
		end else if (iter_q != '0) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (iter_q != '0) begin
			rem_q <= ge ? rsmp_pkg::DW'(trial - {1'b0, den_q}) : trial[rsmp_pkg::DW-1:0];
			num_q <= {num_q[rsmp_pkg::NUMW-2:0], ge};
		end
	end

	assign quo  = num_q;
	assign rem  = rem_q;
	assign busy = iter_q != '0;
endmodule

// File: rtl/rsmp_dp.sv
// Resampler datapath: spacing register, shared multiplier, sqrt iteration,
// interpolation accumulators and output register. Depends on rsmp_pkg, rsmp_div.
`timescale 1ns / 1ps
module rsmp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsmp_pkg::cmd_t              cmd,
	output rsmp_pkg::stat_t             st,
	input  logic                        cfg_we,
	input  logic [rsmp_pkg::SPW-1:0]    cfg_data,
	input  logic [2:0][rsmp_pkg::CW-1:0] prev,
	input  logic [2:0][rsmp_pkg::CW-1:0] cur,
	output logic                        o_valid,
	input  logic                        o_ready,
	output logic [rsmp_pkg::CW-1:0]     o_x,
	output logic [rsmp_pkg::CW-1:0]     o_y,
	output logic [rsmp_pkg::CW-1:0]     o_yaw,
	output logic                        o_last,
	output logic                        o_cut
);
	localparam int CW  = rsmp_pkg::CW;
	localparam int DW  = rsmp_pkg::DW;
	localparam int NAX = rsmp_pkg::NAX;

	logic [rsmp_pkg::SPW-1:0] spacing_q;
	logic [CW-1:0]            owed_q;
	logic [CW-1:0]            base_q [NAX];
	logic [CW-1:0]            mag_q  [NAX];
	logic                     neg_q  [NAX];
	logic [CW-1:0]            q_q    [NAX];
	logic [DW-1:0]            r_q    [NAX];
	logic [CW-1:0]            qa_q   [NAX];
	logic [DW-1:0]            ra_q   [NAX];
	logic [rsmp_pkg::SQW-1:0] sq_q;
	logic [rsmp_pkg::SRW-1:0] srem_q;
	logic [DW-1:0]            root_q;
	logic [DW-1:0]            d_q;
	logic [DW-1:0]            rest_q;
	logic [rsmp_pkg::NUMW-1:0] prod_q;
	logic [rsmp_pkg::PTW-1:0] n_m1_q;
	logic                     cut_q;
	logic                     ovld_q;
	logic [CW-1:0]            ox_q, oy_q, oyaw_q;
	logic                     olast_q, ocut_q;

	logic [rsmp_pkg::SPW-1:0]  step;
	logic [CW-1:0]             mul_a, mul_b;
	logic [rsmp_pkg::NUMW-1:0] mul_p;
	logic [rsmp_pkg::SRW-1:0]  s_trial, s_cand;
	logic                      s_ge;
	logic                      div_start;
	logic [rsmp_pkg::NUMW-1:0] div_num;
	logic [DW-1:0]             div_den;
	logic [rsmp_pkg::NUMW-1:0] div_quo;
	logic [DW-1:0]             div_rem;
	logic                      div_busy;
	logic                      d_zero;
	logic [CW-1:0]             pt   [NAX];
	logic [DW:0]               racc [NAX];

	assign step   = (spacing_q == '0) ? rsmp_pkg::SPW'(1) : spacing_q;
	assign d_zero = d_q == '0;

	// shared multiplier
	always_comb begin
		mul_a = mag_q[cmd.axis];
		mul_b = owed_q;
		case (cmd.op)
			rsmp_pkg::OP_SQX: begin
				mul_a = mag_q[0];
				mul_b = mag_q[0];
			end
			rsmp_pkg::OP_SQY: begin
				mul_a = mag_q[1];
				mul_b = mag_q[1];
			end
			rsmp_pkg::OP_MUL_ST: mul_b = CW'(step);
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// digit-by-digit square root, two radicand bits a cycle
	assign s_cand  = {srem_q[rsmp_pkg::SRW-3:0], sq_q[rsmp_pkg::SQW-1 -: 2]};
	assign s_trial = rsmp_pkg::SRW'({root_q, 2'b01});
	assign s_ge    = s_cand >= s_trial;

	assign div_start = cmd.op == rsmp_pkg::OP_DIV_PROD || cmd.op == rsmp_pkg::OP_DIV_CNT;
	assign div_num   = (cmd.op == rsmp_pkg::OP_DIV_CNT) ?
		rsmp_pkg::NUMW'(rest_q) : prod_q;
	assign div_den   = (cmd.op == rsmp_pkg::OP_DIV_CNT) ? DW'(step) : d_q;

	rsmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rem    (div_rem),
		.busy   (div_busy)
	);

	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			pt[i]   = neg_q[i] ? base_q[i] - q_q[i] : base_q[i] + q_q[i];
			racc[i] = {1'b0, r_q[i]} + {1'b0, ra_q[i]};
		end
	end

	// control state: spacing, owed distance, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= rsmp_pkg::SPACING_RESET;
			owed_q    <= '0;
			ovld_q    <= 1'b0;
		end else begin
			if (cfg_we)
				spacing_q <= cfg_data;
			if (cmd.op == rsmp_pkg::OP_CMP && d_q < {1'b0, owed_q})
				owed_q <= owed_q - d_q[CW-1:0];
			else if (cmd.op == rsmp_pkg::OP_CNT_WR)
				owed_q <= CW'(step - div_rem[rsmp_pkg::SPW-1:0]);
			if (cmd.op == rsmp_pkg::OP_EMIT)
				ovld_q <= 1'b1;
			else if (o_ready)
				ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rsmp_pkg::OP_LOAD: begin
				for (int i = 0; i < NAX; i++) begin
					logic [CW:0] diff;
					diff      = {cur[i][CW-1], cur[i]} - {prev[i][CW-1], prev[i]};
					base_q[i] <= prev[i];
					neg_q[i]  <= diff[CW];
					mag_q[i]  <= diff[CW] ? CW'(-diff) : diff[CW-1:0];
				end
			end
			rsmp_pkg::OP_SQX: begin
				sq_q   <= rsmp_pkg::SQW'(mul_p);
				srem_q <= '0;
				root_q <= '0;
			end
			rsmp_pkg::OP_SQY: sq_q <= sq_q + rsmp_pkg::SQW'(mul_p);
			rsmp_pkg::OP_SQRT: begin
				sq_q   <= {sq_q[rsmp_pkg::SQW-3:0], 2'b00};
				srem_q <= s_ge ? s_cand - s_trial : s_cand;
				root_q <= {root_q[DW-2:0], s_ge};
				d_q    <= {root_q[DW-2:0], s_ge};
			end
			rsmp_pkg::OP_CMP: rest_q <= d_q - {1'b0, owed_q};
			rsmp_pkg::OP_MUL_OW, rsmp_pkg::OP_MUL_ST: prod_q <= mul_p;
			rsmp_pkg::OP_WR_Q: begin
				q_q[cmd.axis] <= d_zero ? '0 : div_quo[CW-1:0];
				r_q[cmd.axis] <= d_zero ? '0 : div_rem;
			end
			rsmp_pkg::OP_WR_QA: begin
				qa_q[cmd.axis] <= d_zero ? '0 : div_quo[CW-1:0];
				ra_q[cmd.axis] <= d_zero ? '0 : div_rem;
			end
			rsmp_pkg::OP_CNT_WR: begin
				cut_q  <= div_quo > rsmp_pkg::NUMW'(rsmp_pkg::LAST_IDX);
				n_m1_q <= (div_quo > rsmp_pkg::NUMW'(rsmp_pkg::LAST_IDX)) ?
					rsmp_pkg::LAST_IDX : div_quo[rsmp_pkg::PTW-1:0];
			end
			rsmp_pkg::OP_EMIT: begin
				ox_q    <= pt[0];
				oy_q    <= pt[1];
				oyaw_q  <= pt[2];
				olast_q <= cmd.last;
				ocut_q  <= cut_q;
				// step to the next point: q += qa with remainder carry
				for (int i = 0; i < NAX; i++) begin
					if (racc[i] >= {1'b0, d_q}) begin
						r_q[i] <= DW'(racc[i] - {1'b0, d_q});
						q_q[i] <= q_q[i] + qa_q[i] + 1'b1;
					end else begin
						r_q[i] <= racc[i][DW-1:0];
						q_q[i] <= q_q[i] + qa_q[i];
					end
				end
			end
			default: ;
		endcase
	end

	assign st.short_seg = d_q < {1'b0, owed_q};
	assign st.div_busy  = div_busy;
	assign st.out_free  = !ovld_q || o_ready;
	assign st.n_m1      = n_m1_q;

	assign o_valid = ovld_q;
	assign o_x     = ox_q;
	assign o_y     = oy_q;
	assign o_yaw   = oyaw_q;
	assign o_last  = olast_q;
	assign o_cut   = ocut_q;
endmodule

// File: rtl/rsmp_ctrl.sv
// Resampler controller: sequences the datapath through length, divisions and
// point emission. Depends on rsmp_pkg.
`timescale 1ns / 1ps
module rsmp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rsmp_pkg::stat_t st,
	output rsmp_pkg::cmd_t  cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQX  = 4'd1;
	localparam logic [3:0] S_SQY  = 4'd2;
	localparam logic [3:0] S_SQRT = 4'd3;
	localparam logic [3:0] S_CMP  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIVS = 4'd6;
	localparam logic [3:0] S_DIVW = 4'd7;
	localparam logic [3:0] S_CNTS = 4'd8;
	localparam logic [3:0] S_CNTW = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;

	logic [3:0]                state_q, state_d;
	logic [rsmp_pkg::CNTW-1:0] it_q, it_d;
	logic [1:0]                axis_q, axis_d;
	logic                      ph_q, ph_d;
	logic [rsmp_pkg::PTW-1:0]  k_q, k_d;

	always_comb begin
		state_d  = state_q;
		it_d     = it_q;
		axis_d   = axis_q;
		ph_d     = ph_q;
		k_d      = k_q;
		cmd.op   = rsmp_pkg::OP_NONE;
		cmd.axis = axis_q;
		cmd.last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = rsmp_pkg::OP_LOAD;
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				cmd.op  = rsmp_pkg::OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = rsmp_pkg::OP_SQY;
				it_d    = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = rsmp_pkg::OP_SQRT;
				it_d   = it_q + 1'b1;
				if (it_q == rsmp_pkg::CNTW'(rsmp_pkg::SQRT_ITERS - 1))
					state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = rsmp_pkg::OP_CMP;
				axis_d  = '0;
				ph_d    = 1'b0;
				state_d = st.short_seg ? S_IDLE : S_MUL;
			end
			S_MUL: begin
				cmd.op  = ph_q ? rsmp_pkg::OP_MUL_ST : rsmp_pkg::OP_MUL_OW;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.op  = rsmp_pkg::OP_DIV_PROD;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (!st.div_busy) begin
					cmd.op = ph_q ? rsmp_pkg::OP_WR_QA : rsmp_pkg::OP_WR_Q;
					ph_d   = !ph_q;
					if (ph_q && axis_q == 2'(rsmp_pkg::NAX - 1)) begin
						state_d = S_CNTS;
					end else begin
						axis_d  = ph_q ? axis_q + 1'b1 : axis_q;
						state_d = S_MUL;
					end
				end
			end
			S_CNTS: begin
				cmd.op  = rsmp_pkg::OP_DIV_CNT;
				state_d = S_CNTW;
			end
			S_CNTW: begin
				if (!st.div_busy) begin
					cmd.op  = rsmp_pkg::OP_CNT_WR;
					k_d     = '0;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.op   = rsmp_pkg::OP_EMIT;
					cmd.last = k_q == st.n_m1;
					k_d      = k_q + 1'b1;
					if (k_q == st.n_m1)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			it_q    <= '0;
			axis_q  <= '0;
			ph_q    <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			it_q    <= it_d;
			axis_q  <= axis_d;
			ph_q    <= ph_d;
			k_q     <= k_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rsmp_pkg::OP_EMIT |-> st.out_free)
		else $error("point emitted over an untaken one");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rsmp_pkg::OP_DIV_PROD || cmd.op == rsmp_pkg::OP_DIV_CNT) |-> !st.div_busy)
		else $error("divider restarted while busy");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> k_q <= st.n_m1)
		else $error("point index past point count");
	a_axis_bound: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q <= 2'(rsmp_pkg::NAX - 1))
		else $error("axis index out of range");
endmodule

// File: rtl/path_resampler_fixed_spacing.sv
// Top level of the fixed-spacing path resampler: channel ports, controller
// and datapath. Depends on rsmp_pkg, the rsmp_*_if interfaces, rsmp_ctrl, rsmp_dp.
`timescale 1ns / 1ps
//
//  port  | dir | item                                     | handshake
//  ------+-----+------------------------------------------+-----------
//  seg   | in  | prev_x/y/yaw, cur_x/y/yaw, Q16.16 signed | valid/ready
//  pnt   | out | out_x/y/yaw, last_point, truncated       | valid/ready
//  cfg   | in  | spacing, unsigned Q16.16, 23 bit         | valid/ready
//
//  One segment at a time. A segment's points are emitted one a cycle when pnt
//  is not stalled; a segment shorter than the owed distance emits none and
//  skips the divisions. Seven divisions on the shared divider (two per axis
//  and the point count) follow the 33-step square root for the segment
//  length.
//  arst_n clears the controller, the owed distance and the output valid, and
//  loads the 0.05 m spacing. The last point waits in the output register while
//  the next segment is taken; a stall on pnt holds emission, never data.
//
module path_resampler_fixed_spacing (
	input logic        clk,
	input logic        arst_n,
	rsmp_seg_if.sink   seg,
	rsmp_pnt_if.source pnt,
	rsmp_cfg_if.sink   cfg
);
	rsmp_pkg::cmd_t   cmd;
	rsmp_pkg::stat_t  st;
	logic [2:0][31:0] prev, cur;
	logic [31:0]      o_x, o_y, o_yaw;

	// lane order: x, y, yaw
	assign prev = {seg.prev_yaw, seg.prev_y, seg.prev_x};
	assign cur  = {seg.cur_yaw, seg.cur_y, seg.cur_x};

	// spacing is always writable; the host writes only while idle, the block does not enforce it
	assign cfg.ready = 1'b1;

	rsmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (seg.valid),
		.in_ready (seg.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rsmp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.spacing),
		.prev     (prev),
		.cur      (cur),
		.o_valid  (pnt.valid),
		.o_ready  (pnt.ready),
		.o_x      (o_x),
		.o_y      (o_y),
		.o_yaw    (o_yaw),
		.o_last   (pnt.last_point),
		.o_cut    (pnt.truncated)
	);

	assign pnt.out_x   = signed'(o_x);
	assign pnt.out_y   = signed'(o_y);
	assign pnt.out_yaw = signed'(o_yaw);
endmodule

// File: test/path_resampler_fixed_spacing_test.sv
// Self-checking bench for the fixed-spacing path resampler: drives segments and
// spacing writes, predicts each resampled point and checks it in order.
// Depends on rsmp_pkg, the rsmp_*_if interfaces and path_resampler_fixed_spacing.
`timescale 1ns / 1ps

// one expected resampled point
typedef struct {
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic signed [31:0] yaw;
	logic               last_point;
	logic               truncated;
} rsmp_point_t;

class resample_scoreboard;
	logic [rsmp_pkg::SPW-1:0] spacing;
	logic [31:0]              owed;
	rsmp_point_t              pending[$];
	int                       errors;
	int                       points_seen;
	int                       cut_segments;
	int                       short_segments;

	function void reset_state();
		spacing = rsmp_pkg::SPACING_RESET;
		owed    = '0;
	endfunction

	// floor square root of a 66-bit value
	function logic [32:0] root(logic [65:0] v);
		logic [32:0]  r;
		logic [33:0]  c;
		logic [67:0]  sq;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			c  = {1'b0, r} | (34'd1 << b);
			sq = c * c;
			if (sq <= {2'b00, v})
				r = c[32:0];
		end
		return r;
	endfunction

	// start + delta * t / d, offset truncated toward zero
	function logic [31:0] interp(logic signed [33:0] start, logic signed [33:0] delta,
			logic [63:0] t, logic [32:0] d);
		logic [33:0]         mag;
		logic [127:0]        q;
		logic signed [63:0]  v;
		if (d == 0)
			return start[31:0];
		mag = delta < 0 ? 34'(-delta) : 34'(delta);
		q   = (128'(mag) * 128'(t)) / 128'(d);
		v   = delta < 0 ? 64'(start) - 64'(q) : 64'(start) + 64'(q);
		return v[31:0];
	endfunction

	function void note_segment(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pyaw, logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cyaw);
		logic signed [33:0] dx, dy, dyaw;
		logic [33:0]        ax, ay;
		logic [32:0]        d;
		logic [63:0]        step, rest, cnt, n;
		bit                 cut;
		rsmp_point_t        p;
		dx   = 34'(cx) - 34'(px);
		dy   = 34'(cy) - 34'(py);
		dyaw = 34'(cyaw) - 34'(pyaw);
		ax   = dx < 0 ? 34'(-dx) : 34'(dx);
		ay   = dy < 0 ? 34'(-dy) : 34'(dy);
		d    = root(66'(ax) * 66'(ax) + 66'(ay) * 66'(ay));
		step = spacing != 0 ? 64'(spacing) : 64'd1;
		if (64'(d) < 64'(owed)) begin
			owed = owed - d[31:0];
			short_segments++;
			return;
		end
		rest = 64'(d) - 64'(owed);
		cnt  = rest / step;
		cut  = cnt + 1 > rsmp_pkg::MAX_POINTS;
		n    = cut ? rsmp_pkg::MAX_POINTS : cnt + 1;
		if (cut)
			cut_segments++;
		for (int k = 0; k < n; k++) begin
			p.x          = interp(34'(px), dx, 64'(owed) + k * step, d);
			p.y          = interp(34'(py), dy, 64'(owed) + k * step, d);
			p.yaw        = interp(34'(pyaw), dyaw, 64'(owed) + k * step, d);
			p.last_point = (k + 1 == n);
			p.truncated  = cut;
			pending.push_back(p);
		end
		owed = 32'(step - (rest - cnt * step));
	endfunction

	task check_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] yaw, logic lp, logic tr);
		rsmp_point_t e;
		points_seen++;
		if (pending.size() == 0) begin
			report_mismatch("point with nothing expected");
			return;
		end
		e = pending.pop_front();
		if (x !== e.x)
			report_mismatch($sformatf("out_x %0d, expected %0d", x, e.x));
		if (y !== e.y)
			report_mismatch($sformatf("out_y %0d, expected %0d", y, e.y));
		if (yaw !== e.yaw)
			report_mismatch($sformatf("out_yaw %0d, expected %0d", yaw, e.yaw));
		if (lp !== e.last_point)
			report_mismatch($sformatf("last_point %0b, expected %0b", lp, e.last_point));
		if (tr !== e.truncated)
			report_mismatch($sformatf("truncated %0b, expected %0b", tr, e.truncated));
	endtask

	task report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask
endclass

module path_resampler_fixed_spacing_test;
	logic clk;
	logic arst_n;
	bit   no_idle;   // long stretch with both sides always active
	bit   stim_done;

	rsmp_seg_if seg();
	rsmp_pnt_if pnt();
	rsmp_cfg_if cfg();

	resample_scoreboard sb;

	path_resampler_fixed_spacing i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.seg   (seg.sink),
		.pnt   (pnt.source),
		.cfg   (cfg.sink)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// both sides idle at random, about 29 times in a hundred, unless no_idle is set
	function bit idle_now();
		return !no_idle && $urandom_range(99) < 29;
	endfunction

	// --- point sink: random stalls, sampled at the rising edge ---
	initial begin
		pnt.ready = 1'b0;
		forever begin
			@(negedge clk);
			pnt.ready <= !idle_now();
		end
	end

	always @(posedge clk)
		if (arst_n && pnt.valid && pnt.ready)
			sb.check_point(pnt.out_x, pnt.out_y, pnt.out_yaw, pnt.last_point,
				pnt.truncated);

	// offer one segment, holding it until taken; starts a falling edge after
	// the previous drive so valid is never driven twice in one step
	task send_segment(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pyaw, logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cyaw);
		@(negedge clk);
		while (idle_now())
			@(negedge clk);
		seg.valid    <= 1'b1;
		seg.prev_x   <= px;
		seg.prev_y   <= py;
		seg.prev_yaw <= pyaw;
		seg.cur_x    <= cx;
		seg.cur_y    <= cy;
		seg.cur_yaw  <= cyaw;
		@(posedge clk);
		while (!seg.ready)
			@(posedge clk);
		sb.note_segment(px, py, pyaw, cx, cy, cyaw);
		@(negedge clk);
		seg.valid <= 1'b0;
	endtask

	// spacing write, only once the block has drained
	task write_spacing(logic [rsmp_pkg::SPW-1:0] v);
		while (sb.pending.size() != 0)
			@(negedge clk);
		// a short segment gives no point, so wait out its processing too
		repeat (60) @(negedge clk);
		cfg.valid   <= 1'b1;
		cfg.spacing <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.spacing = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// random segment; length scaled around the spacing so most emit a few points
	task random_segment();
		logic signed [31:0] px, py, cx, cy;
		int                 reach;
		px = $urandom;
		py = $urandom;
		case ($urandom_range(9))
			0: reach = 0;
			1: reach = 1 << 30;                  // very long: saturates
			2, 3: reach = sb.spacing / 2 + 1;    // often shorter than the owed distance
			default: reach = sb.spacing * $urandom_range(12) + 1;
		endcase
		if ($urandom_range(19) == 0) begin
			cx = $urandom;                       // fully random endpoint
			cy = $urandom;
		end else begin
			cx = px + $signed(32'($urandom_range(2 * reach))) - reach;
			cy = py + $signed(32'($urandom_range(2 * reach))) - reach;
		end
		send_segment(px, py, $urandom, cx, cy, $urandom);
	endtask

	initial begin
		int n_items;
		sb = new();
		sb.reset_state();
		arst_n      = 1'b0;
		seg.valid   = 1'b0;
		seg.prev_x  = '0;
		seg.prev_y  = '0;
		seg.prev_yaw = '0;
		seg.cur_x   = '0;
		seg.cur_y   = '0;
		seg.cur_yaw = '0;
		cfg.valid   = 1'b0;
		cfg.spacing = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: first segment after reset emits its start point
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd100);      // zero length
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd1000, 32'sd0, 32'sd0);      // shorter than owed
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd6554, 32'sd0, -32'sd6554);  // exact multiple
		send_segment(32'sd0, 32'sd0, -32'sd5, 32'sd3277, 32'sd3277, 32'sd5);
		send_segment(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000);                         // extremes, cut
		send_segment(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h7fffffff);
		send_segment(32'hffffffff, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'hffffffff);
		write_spacing('0);                                                    // zero treated as one
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_segment(32'sd10, 32'sd10, 32'sd0, 32'sd40, 32'sd50, 32'sd1000);
		write_spacing(23'h7fffff);                                            // largest
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd8388607, 32'sd0, 32'sd77);
		send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd8388607, 32'sd0, 32'sd77);
		write_spacing(23'd6553600);
		send_segment(-32'sd1, -32'sd1, 32'sd0, 32'sd6553599, 32'sd0, 32'sd9);

		// random phases across several spacings
		n_items = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_spacing(23'd1);
				1: write_spacing(rsmp_pkg::SPACING_RESET);
				2: write_spacing(23'($urandom_range(1, 23'h7fffff)));
				3: write_spacing(23'($urandom_range(100, 70000)));
				4: write_spacing(23'd6553600);
				default: write_spacing(23'($urandom_range(1, 5000)));
			endcase
			no_idle = (ph == 3);
			for (int i = 0; i < 43; i++) begin
				random_segment();
				n_items++;
			end
		end
		no_idle   = 1'b0;
		stim_done = 1'b1;
	end

	// wrap up once all stimulus is in and every expected point has arrived
	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		$display("Covered %0d points; %0d segments cut at the limit, %0d too short.",
			sb.points_seen, sb.cut_segments, sb.short_segments);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// generous guard: ~280 segments, each with up to 64 points and stalls, plus gaps
	initial begin
		#20ms;
		$display("Timed out with %0d points outstanding", sb.pending.size());
		$display("TEST FAILED");
		$finish;
	end
endmodule

// File: files.f
rtl/rsmp_pkg.sv
rtl/rsmp_seg_if.sv
rtl/rsmp_pnt_if.sv
rtl/rsmp_cfg_if.sv
rtl/rsmp_div.sv
rtl/rsmp_dp.sv
rtl/rsmp_ctrl.sv
rtl/path_resampler_fixed_spacing.sv
test/path_resampler_fixed_spacing_test.sv
